// File: sv/gga_pkg.sv
// shared types, constants and helper functions of the gga sentence parser
// no dependencies; used by every module of the block
`default_nettype none

package gga_pkg;

    // sentence framing characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_NOSIG  = 8'h78;

    // line limit and minute fraction precision
    localparam int GGA_MAX_LINE   = 1024;
    localparam int GGA_FRAC_DIGITS = 5;

    // tag "$GNGGA": length and the position code that marks a mismatch
    localparam logic [2:0] GGA_TAG_LEN  = 3'd6;
    localparam logic [2:0] GGA_TAG_FAIL = 3'd7;

    // field numbers of the sentence
    localparam logic [3:0] FLD_LAT      = 4'd2;
    localparam logic [3:0] FLD_LAT_HEMI = 4'd3;
    localparam logic [3:0] FLD_LON      = 4'd4;
    localparam logic [3:0] FLD_LON_HEMI = 4'd5;
    localparam logic [3:0] FLD_QUALITY  = 4'd6;
    localparam logic [3:0] FLD_SATS     = 4'd7;
    localparam logic [3:0] FLD_MAX      = 4'd15;
    localparam logic [3:0] CHAR_MAX     = 4'd15;
    localparam logic [2:0] COMMA_RUN_NOSIG = 3'd5;

    // degree digits per coordinate and accumulator caps
    localparam logic [3:0]  LAT_DEG_DIGITS = 4'd2;
    localparam logic [3:0]  LON_DEG_DIGITS = 4'd3;
    localparam logic [14:0] WHOLE_CAP      = 15'd20000;
    localparam logic [3:0]  QUALITY_CAP    = 4'd9;
    localparam logic [6:0]  SATS_CAP       = 7'd99;

    // field widths
    localparam int LAT_DEG_W = 7;
    localparam int LON_DEG_W = 10;
    localparam int WHOLE_W   = 15;
    localparam int FRAC_W    = 24;
    localparam int LAT_OUT_W = 30;
    localparam int LON_OUT_W = 31;
    localparam int LAT_LIMIT_DEG = 90;
    localparam int LON_LIMIT_DEG = 180;

    // conversion constants: 1e7 units, divide by 60 through reciprocals
    localparam int GGA_E7       = 10000000;
    localparam int RECIP_W_MUL  = 17477;
    localparam int RECIP_W_SHR  = 20;
    localparam int A_W          = 9;
    localparam int B_W          = 6;
    localparam int Y_W          = 30;
    localparam longint RECIP_Y_MUL = 64'd572662307;
    localparam int RECIP_Y_SHR  = 35;
    localparam int Q_W          = 25;

    // record queue depth
    localparam int GGA_QDEPTH = 4;

    // one parsed sentence, handed from front to back
    typedef struct packed {
        logic [LAT_DEG_W-1:0] lat_deg;
        logic [WHOLE_W-1:0]   lat_whole;
        logic [FRAC_W-1:0]    lat_frac;
        logic [LON_DEG_W-1:0] lon_deg;
        logic [WHOLE_W-1:0]   lon_whole;
        logic [FRAC_W-1:0]    lon_frac;
        logic [7:0]           lat_hemi;
        logic [7:0]           lon_hemi;
        logic [3:0]           quality;
        logic [6:0]           sats;
        logic                 no_sig;
    } gga_rec_t;

    // queue write from the front
    typedef struct packed {
        logic     en;
        gga_rec_t rec;
    } gga_push_t;

    // fields that ride along the conversion pipeline
    typedef struct packed {
        logic [7:0] lat_hemi;
        logic [7:0] lon_hemi;
        logic [3:0] quality;
        logic [6:0] sats;
        logic       no_sig;
    } gga_side_t;

    // expected tag character at a prefix position
    function automatic logic [7:0] gga_tag_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h4E;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h47;
            3'd5:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // powers of ten up to 1e7
    function automatic logic [FRAC_W-1:0] gga_pow10(input logic [2:0] idx);
        logic [FRAC_W-1:0] p;
        unique case (idx)
            3'd0: p = 24'd1;
            3'd1: p = 24'd10;
            3'd2: p = 24'd100;
            3'd3: p = 24'd1000;
            3'd4: p = 24'd10000;
            3'd5: p = 24'd100000;
            3'd6: p = 24'd1000000;
            3'd7: p = 24'd10000000;
            default: p = 24'd1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// File: sv/gga_front.sv
// byte-level sentence tracker: framing, tag match, field digit accumulation
// depends on gga_pkg; pushes one record per accepted sentence into gga_queue
`default_nettype none

module gga_front #(
    parameter int MAX_LINE = gga_pkg::GGA_MAX_LINE
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             take,
    input  wire logic [7:0]       rx_byte,
    output gga_pkg::gga_push_t    wr
);

    localparam int LEN_W = $clog2(MAX_LINE + 1);

    logic             in_sent_reg, in_sent_next;
    logic [2:0]       prefix_pos_reg, prefix_pos_next;
    logic             prefix_match_reg, prefix_match_next;
    logic [LEN_W-1:0] line_len_reg, line_len_next;
    logic [3:0]       field_num_reg, field_num_next;
    logic [3:0]       char_idx_reg, char_idx_next;
    logic [2:0]       comma_run_reg, comma_run_next;
    logic             empty_seen_reg, empty_seen_next;
    logic [2:0]       frac_cnt_reg, frac_cnt_next;
    logic             seen_point_reg, seen_point_next;
    gga_pkg::gga_rec_t acc_reg, acc_next;

    logic             is_digit;
    logic [3:0]       dval;
    logic [2:0]       prefix_inc;
    logic [2:0]       pow_idx;

    // saturating whole-minute step
    function automatic logic [gga_pkg::WHOLE_W-1:0] whole_step(
        input logic [gga_pkg::WHOLE_W-1:0] w,
        input logic [3:0] d
    );
        logic [17:0] v;
        v = 18'(w) * 18'd10 + 18'(d);
        return (v > 18'(gga_pkg::WHOLE_CAP)) ? gga_pkg::WHOLE_CAP
                                              : v[gga_pkg::WHOLE_W-1:0];
    endfunction

    // saturating decimal step, value kept in 7 bits
    function automatic logic [6:0] dec_step(
        input logic [6:0] acc,
        input logic [3:0] d,
        input logic [6:0] cap
    );
        logic [10:0] v;
        v = 11'(acc) * 11'd10 + 11'(d);
        return (v > 11'(cap)) ? cap : v[6:0];
    endfunction

    assign is_digit   = (rx_byte >= gga_pkg::CH_ZERO) && (rx_byte <= gga_pkg::CH_NINE);
    assign dval       = is_digit ? 4'(rx_byte - gga_pkg::CH_ZERO) : 4'd0;
    assign prefix_inc = prefix_pos_reg + 3'd1;
    assign pow_idx    = 3'(gga_pkg::GGA_FRAC_DIGITS - 1) - frac_cnt_reg;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sent_reg      <= 1'b0;
            prefix_pos_reg   <= '0;
            prefix_match_reg <= 1'b0;
            line_len_reg     <= '0;
            field_num_reg    <= '0;
            char_idx_reg     <= '0;
            comma_run_reg    <= '0;
            empty_seen_reg   <= 1'b0;
            frac_cnt_reg     <= '0;
            seen_point_reg   <= 1'b0;
            acc_reg          <= '0;
        end
        else
        begin
            in_sent_reg      <= in_sent_next;
            prefix_pos_reg   <= prefix_pos_next;
            prefix_match_reg <= prefix_match_next;
            line_len_reg     <= line_len_next;
            field_num_reg    <= field_num_next;
            char_idx_reg     <= char_idx_next;
            comma_run_reg    <= comma_run_next;
            empty_seen_reg   <= empty_seen_next;
            frac_cnt_reg     <= frac_cnt_next;
            seen_point_reg   <= seen_point_next;
            acc_reg          <= acc_next;
        end
    end

    // per-item update
    always_comb
    begin
        in_sent_next      = in_sent_reg;
        prefix_pos_next   = prefix_pos_reg;
        prefix_match_next = prefix_match_reg;
        line_len_next     = line_len_reg;
        field_num_next    = field_num_reg;
        char_idx_next     = char_idx_reg;
        comma_run_next    = comma_run_reg;
        empty_seen_next   = empty_seen_reg;
        frac_cnt_next     = frac_cnt_reg;
        seen_point_next   = seen_point_reg;
        acc_next          = acc_reg;
        wr.en             = 1'b0;
        wr.rec            = acc_reg;
        wr.rec.no_sig     = empty_seen_reg;

        if (take)
        begin
            if (rx_byte == gga_pkg::CH_DOLLAR)
            begin
                // start of sentence, drops any sentence under way
                in_sent_next      = 1'b1;
                prefix_pos_next   = 3'd1;
                prefix_match_next = 1'b0;
                line_len_next     = LEN_W'(1);
                field_num_next    = '0;
                char_idx_next     = '0;
                comma_run_next    = '0;
                empty_seen_next   = 1'b0;
                frac_cnt_next     = '0;
                seen_point_next   = 1'b0;
                acc_next          = '0;
            end
            else if (in_sent_reg)
            begin
                if (line_len_reg >= LEN_W'(MAX_LINE))
                begin
                    // overlong line
                    in_sent_next = 1'b0;
                end
                else
                begin
                    line_len_next = line_len_reg + LEN_W'(1);
                    if (rx_byte == gga_pkg::CH_LF)
                    begin
                        in_sent_next = 1'b0;
                        wr.en        = prefix_match_reg;
                    end
                    else
                    begin
                        // tag match on the first six bytes
                        if ((line_len_reg <= LEN_W'(gga_pkg::GGA_TAG_LEN - 3'd1)) &&
                            (LEN_W'(prefix_pos_reg) == line_len_reg))
                        begin
                            if (rx_byte == gga_pkg::gga_tag_char(prefix_pos_reg))
                            begin
                                prefix_pos_next = prefix_inc;
                                if (prefix_inc == gga_pkg::GGA_TAG_LEN)
                                    prefix_match_next = 1'b1;
                            end
                            else
                            begin
                                prefix_pos_next = gga_pkg::GGA_TAG_FAIL;
                            end
                        end

                        if (rx_byte == gga_pkg::CH_COMMA)
                        begin
                            // field separator
                            if (comma_run_reg < gga_pkg::COMMA_RUN_NOSIG)
                                comma_run_next = comma_run_reg + 3'd1;
                            if (comma_run_next == gga_pkg::COMMA_RUN_NOSIG)
                                empty_seen_next = 1'b1;
                            if (field_num_reg < gga_pkg::FLD_MAX)
                                field_num_next = field_num_reg + 4'd1;
                            char_idx_next   = '0;
                            frac_cnt_next   = '0;
                            seen_point_next = 1'b0;
                        end
                        else
                        begin
                            comma_run_next = '0;
                            unique case (field_num_reg)
                                gga_pkg::FLD_LAT:
                                begin
                                    if (char_idx_reg < gga_pkg::LAT_DEG_DIGITS)
                                        acc_next.lat_deg = gga_pkg::LAT_DEG_W'(
                                            14'(acc_reg.lat_deg) * 14'd10 + 14'(dval));
                                    else if (rx_byte == gga_pkg::CH_POINT)
                                        seen_point_next = 1'b1;
                                    else if (is_digit && !seen_point_reg)
                                        acc_next.lat_whole = whole_step(acc_reg.lat_whole, dval);
                                    else if (is_digit &&
                                             (frac_cnt_reg < 3'(gga_pkg::GGA_FRAC_DIGITS)))
                                    begin
                                        acc_next.lat_frac = acc_reg.lat_frac +
                                            gga_pkg::FRAC_W'(dval) * gga_pkg::gga_pow10(pow_idx);
                                        frac_cnt_next = frac_cnt_reg + 3'd1;
                                    end
                                end
                                gga_pkg::FLD_LAT_HEMI:
                                begin
                                    if (char_idx_reg == 4'd0)
                                        acc_next.lat_hemi = rx_byte;
                                end
                                gga_pkg::FLD_LON:
                                begin
                                    if (char_idx_reg < gga_pkg::LON_DEG_DIGITS)
                                        acc_next.lon_deg = gga_pkg::LON_DEG_W'(
                                            14'(acc_reg.lon_deg) * 14'd10 + 14'(dval));
                                    else if (rx_byte == gga_pkg::CH_POINT)
                                        seen_point_next = 1'b1;
                                    else if (is_digit && !seen_point_reg)
                                        acc_next.lon_whole = whole_step(acc_reg.lon_whole, dval);
                                    else if (is_digit &&
                                             (frac_cnt_reg < 3'(gga_pkg::GGA_FRAC_DIGITS)))
                                    begin
                                        acc_next.lon_frac = acc_reg.lon_frac +
                                            gga_pkg::FRAC_W'(dval) * gga_pkg::gga_pow10(pow_idx);
                                        frac_cnt_next = frac_cnt_reg + 3'd1;
                                    end
                                end
                                gga_pkg::FLD_LON_HEMI:
                                begin
                                    if (char_idx_reg == 4'd0)
                                        acc_next.lon_hemi = rx_byte;
                                end
                                gga_pkg::FLD_QUALITY:
                                begin
                                    if (is_digit)
                                        acc_next.quality = 4'(dec_step(7'(acc_reg.quality), dval,
                                                                       7'(gga_pkg::QUALITY_CAP)));
                                end
                                gga_pkg::FLD_SATS:
                                begin
                                    if (is_digit)
                                        acc_next.sats = dec_step(acc_reg.sats, dval,
                                                                 gga_pkg::SATS_CAP);
                                end
                                default:
                                begin
                                end
                            endcase
                            if (char_idx_reg < gga_pkg::CHAR_MAX)
                                char_idx_next = char_idx_reg + 4'd1;
                        end
                    end
                end
            end
        end
    end

`ifndef SYNTH
    // a matched tag always sits at the end of the tag
    a_match_pos: assert property (@(posedge clk) disable iff (!rst_n)
        prefix_match_reg |-> (prefix_pos_reg == gga_pkg::GGA_TAG_LEN))
        else $error("tag matched with prefix position off the tag end");

    // a record only leaves at a line end of a tracked sentence
    a_push_lf: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (take && in_sent_reg && (rx_byte == gga_pkg::CH_LF)))
        else $error("record pushed outside a line end");
`endif

endmodule

`default_nettype wire

// File: sv/gga_queue.sv
// short record queue between the byte front and the conversion back
// depends on gga_pkg for the record type and depth
`default_nettype none

module gga_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  gga_pkg::gga_push_t      wr,
    output logic                    full,
    input  wire logic               rd_en,
    output logic                    rd_valid,
    output gga_pkg::gga_rec_t       rd_data
);

    localparam int DEPTH = gga_pkg::GGA_QDEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gga_pkg::gga_rec_t slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_wr, do_rd;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr.en;
    assign do_rd    = rd_en && rd_valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr.rec;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

`ifndef SYNTH
    // the front never writes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> !full)
        else $error("record written into full queue");
`endif

endmodule

`default_nettype wire

// File: sv/gga_conv.sv
// five-stage conversion of degrees plus minutes into 1e-7 degree units, clamped
// depends on gga_pkg; instantiated by gga_back for latitude and longitude
`default_nettype none

module gga_conv #(
    parameter int DEG_W     = gga_pkg::LAT_DEG_W,
    parameter int OUT_W     = gga_pkg::LAT_OUT_W,
    parameter int LIMIT_DEG = gga_pkg::LAT_LIMIT_DEG
) (
    input  wire logic                        clk,
    input  wire logic                        adv,
    input  wire logic [DEG_W-1:0]            deg,
    input  wire logic [gga_pkg::WHOLE_W-1:0] whole,
    input  wire logic [gga_pkg::FRAC_W-1:0]  frac,
    output logic [OUT_W-1:0]                 value
);

    localparam int WHOLE_W    = gga_pkg::WHOLE_W;
    localparam int FRAC_W     = gga_pkg::FRAC_W;
    localparam int PA_W       = 2 * WHOLE_W;
    localparam int S_W        = DEG_W + 2;
    localparam int PQ_W       = 2 * gga_pkg::Y_W;
    localparam int FRAC_SCALE = 10 ** (7 - gga_pkg::GGA_FRAC_DIGITS);
    localparam logic [OUT_W-1:0] LIMIT = OUT_W'(longint'(LIMIT_DEG) * gga_pkg::GGA_E7);

    // stage 1: whole minutes times reciprocal of 60
    logic [WHOLE_W-1:0] whole1_reg;
    logic [FRAC_W-1:0]  frac1_reg;
    logic [DEG_W-1:0]   deg1_reg;
    logic [PA_W-1:0]    prod_a_reg;
    // stage 2: whole degrees from minutes and leftover minutes
    logic [gga_pkg::A_W-1:0] a2_reg, a2_next;
    logic [gga_pkg::B_W-1:0] b2_reg, b2_next;
    logic [FRAC_W-1:0]  frac2_reg;
    logic [DEG_W-1:0]   deg2_reg;
    // stage 3: leftover in 1e-7 minute units and degree sum
    logic [gga_pkg::Y_W-1:0] y3_reg;
    logic [S_W-1:0]     s3_reg;
    // stage 4: leftover times reciprocal of 60
    logic [PQ_W-1:0]    prod_q_reg;
    logic [S_W-1:0]     s4_reg;
    // stage 5: sum and clamp
    logic [OUT_W-1:0]   value_reg, value_next;

    logic [gga_pkg::Q_W-1:0] q5;
    logic [32:0]        sum5;

    assign a2_next = prod_a_reg[gga_pkg::RECIP_W_SHR +: gga_pkg::A_W];
    assign b2_next = gga_pkg::B_W'(whole1_reg - WHOLE_W'(16'(a2_next) * 16'd60));
    assign q5      = prod_q_reg[gga_pkg::RECIP_Y_SHR +: gga_pkg::Q_W];
    assign sum5    = 33'(s4_reg) * 33'(gga_pkg::GGA_E7) + 33'(q5);

    // clamp to the degree limit
    always_comb
    begin
        if (s4_reg >= S_W'(LIMIT_DEG))
            value_next = LIMIT;
        else if (sum5 > 33'(LIMIT))
            value_next = LIMIT;
        else
            value_next = sum5[OUT_W-1:0];
    end

    // pipeline stages, all moving together
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            whole1_reg <= whole;
            frac1_reg  <= frac;
            deg1_reg   <= deg;
            prod_a_reg <= PA_W'(whole) * PA_W'(gga_pkg::RECIP_W_MUL);

            a2_reg     <= a2_next;
            b2_reg     <= b2_next;
            frac2_reg  <= frac1_reg;
            deg2_reg   <= deg1_reg;

            y3_reg     <= gga_pkg::Y_W'(gga_pkg::Y_W'(b2_reg) * gga_pkg::Y_W'(gga_pkg::GGA_E7)
                          + gga_pkg::Y_W'(frac2_reg) * gga_pkg::Y_W'(FRAC_SCALE));
            s3_reg     <= S_W'(deg2_reg) + S_W'(a2_reg);

            prod_q_reg <= PQ_W'(y3_reg) * PQ_W'(gga_pkg::RECIP_Y_MUL);
            s4_reg     <= s3_reg;

            value_reg  <= value_next;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// File: sv/gga_back.sv
// back end: pulls records from the queue, converts both coordinates, holds the result
// depends on gga_pkg and gga_conv
`default_nettype none

module gga_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            rd_valid,
    input  gga_pkg::gga_rec_t                    rd_data,
    output logic                                 rd_en,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [gga_pkg::LAT_OUT_W-1:0]        latitude_e7,
    output logic [gga_pkg::LON_OUT_W-1:0]        longitude_e7,
    output logic [7:0]                           lat_hemisphere,
    output logic [7:0]                           lon_hemisphere,
    output logic [3:0]                           fix_quality,
    output logic [6:0]                           satellite_count,
    output logic                                 no_signal
);

    localparam int STAGES = 5;

    logic [STAGES-1:0]  valid_reg;
    gga_pkg::gga_side_t side_reg [STAGES];
    gga_pkg::gga_side_t side_in;
    gga_pkg::gga_side_t side_out;
    logic               adv;
    logic [gga_pkg::LAT_OUT_W-1:0] lat_raw;
    logic [gga_pkg::LON_OUT_W-1:0] lon_raw;

    // whole pipeline moves unless a finished result is held
    assign adv   = !valid_reg[STAGES-1] || pop;
    assign rd_en = adv && rd_valid;

    assign side_in.lat_hemi = rd_data.lat_hemi;
    assign side_in.lon_hemi = rd_data.lon_hemi;
    assign side_in.quality  = rd_data.quality;
    assign side_in.sats     = rd_data.sats;
    assign side_in.no_sig   = rd_data.no_sig;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[STAGES-2:0], rd_valid};
    end

    // side fields follow the conversion
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < STAGES; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    gga_conv #(
        .DEG_W     (gga_pkg::LAT_DEG_W),
        .OUT_W     (gga_pkg::LAT_OUT_W),
        .LIMIT_DEG (gga_pkg::LAT_LIMIT_DEG)
    ) u_lat (
        .clk   (clk),
        .adv   (adv),
        .deg   (rd_data.lat_deg),
        .whole (rd_data.lat_whole),
        .frac  (rd_data.lat_frac),
        .value (lat_raw)
    );

    gga_conv #(
        .DEG_W     (gga_pkg::LON_DEG_W),
        .OUT_W     (gga_pkg::LON_OUT_W),
        .LIMIT_DEG (gga_pkg::LON_LIMIT_DEG)
    ) u_lon (
        .clk   (clk),
        .adv   (adv),
        .deg   (rd_data.lon_deg),
        .whole (rd_data.lon_whole),
        .frac  (rd_data.lon_frac),
        .value (lon_raw)
    );

    // result, forced when there is no signal
    assign side_out        = side_reg[STAGES-1];
    assign empty           = !valid_reg[STAGES-1];
    assign no_signal       = side_out.no_sig;
    assign latitude_e7     = side_out.no_sig ? '0 : lat_raw;
    assign longitude_e7    = side_out.no_sig ? '0 : lon_raw;
    assign lat_hemisphere  = side_out.no_sig ? gga_pkg::CH_NOSIG : side_out.lat_hemi;
    assign lon_hemisphere  = side_out.no_sig ? gga_pkg::CH_NOSIG : side_out.lon_hemi;
    assign fix_quality     = side_out.no_sig ? 4'd0 : side_out.quality;
    assign satellite_count = side_out.no_sig ? 7'd0 : side_out.sats;

`ifndef SYNTH
    // clamped magnitudes
    a_lat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (latitude_e7 <= gga_pkg::LAT_OUT_W'(900000000)))
        else $error("latitude above 90 degrees");

    a_lon_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (longitude_e7 <= gga_pkg::LON_OUT_W'(1800000000)))
        else $error("longitude above 180 degrees");

    // a new result only appears when the pipeline moved
    a_rise_adv: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> $past(adv))
        else $error("result appeared without pipeline advance");
`endif

endmodule

`default_nettype wire

// File: sv/nmea_gga_position_parser.sv
// GGA position sentence parser, top level: front, record queue, conversion back
// depends on gga_pkg, gga_front, gga_queue, gga_back
//
//   channel   direction   handshake         fields
//   input     in          push / full       rx_byte
//   result    out         empty / pop       latitude_e7, longitude_e7, lat_hemisphere,
//                                           lon_hemisphere, fix_quality, satellite_count,
//                                           no_signal
//
// one byte is taken per cycle while full is low; each byte updates the sentence tracker in that cycle
// a line end of a matched sentence queues one record (queue of four records)
// a record leaves the queue into the conversion pipeline and reaches the result ports
// through its registers and the two divide-by-60 reciprocal multiplications
// full follows only the record queue; a held result stalls the conversion pipeline
// asynchronous reset clears all control state; no clearing pass is needed
`default_nettype none

module nmea_gga_position_parser #(
    parameter int MAX_LINE = gga_pkg::GGA_MAX_LINE
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [7:0]                        rx_byte,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [gga_pkg::LAT_OUT_W-1:0]          latitude_e7,
    output logic [gga_pkg::LON_OUT_W-1:0]          longitude_e7,
    output logic [7:0]                             lat_hemisphere,
    output logic [7:0]                             lon_hemisphere,
    output logic [3:0]                             fix_quality,
    output logic [6:0]                             satellite_count,
    output logic                                   no_signal
);

    gga_pkg::gga_push_t wr;
    gga_pkg::gga_rec_t  rd_data;
    logic               rd_valid;
    logic               rd_en;
    logic               take;

    // item accepted
    assign take = push && !full;

    gga_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .wr      (wr)
    );

    gga_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .full     (full),
        .rd_en    (rd_en),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    gga_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .rd_valid        (rd_valid),
        .rd_data         (rd_data),
        .rd_en           (rd_en),
        .empty           (empty),
        .pop             (pop),
        .latitude_e7     (latitude_e7),
        .longitude_e7    (longitude_e7),
        .lat_hemisphere  (lat_hemisphere),
        .lon_hemisphere  (lon_hemisphere),
        .fix_quality     (fix_quality),
        .satellite_count (satellite_count),
        .no_signal       (no_signal)
    );

endmodule

`default_nettype wire
